// ----- src/vrmp_pkg.sv -----
// Package for the dual-axis velocity ramp block.
// Shared constants, register indexes and the per-axis flag struct; no dependencies.
`default_nettype none

package vrmp_pkg;

  // Default fixed-point format: signed Q16.16 in 32 bits
  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Tick time is unsigned Q0.16 seconds
  localparam int DT_BITS = 16;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_LIN_ACCEL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIN_DECEL = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ANG_ACCEL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ANG_DECEL = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIN_EN   = 3'd4;

  // Request kinds carried in tuser
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_ENABLE = 1'b1;

  // Per-axis flags worked out at input capture
  typedef struct packed {
    logic dir_pos;  // target above measured
    logic dir_neg;  // target below measured
    logic still;    // measured speed under the stillness limit
  } axis_flags_t;

endpackage

`default_nettype wire

// ----- src/vrmp_prep.sv -----
// Per-axis input preparation: direction, stillness and the step size (limit * dt).
// Depends on vrmp_pkg.
`default_nettype none

module vrmp_prep #(
  parameter int    VALUE_WIDTH = vrmp_pkg::VALUE_WIDTH_DEF,
  parameter longint STILL_LIMIT = 64'sd65536
) (
  input  wire logic signed [VALUE_WIDTH-1:0] target,
  input  wire logic signed [VALUE_WIDTH-1:0] meas,
  input  wire logic        [VALUE_WIDTH-2:0] accel,
  input  wire logic        [VALUE_WIDTH-2:0] decel,
  input  wire logic [vrmp_pkg::DT_BITS-1:0]  dt,
  output vrmp_pkg::axis_flags_t              flags,
  output logic             [VALUE_WIDTH-2:0] step
);

  localparam int PROD_W = VALUE_WIDTH - 1 + vrmp_pkg::DT_BITS;

  logic              grow;
  logic [VALUE_WIDTH-2:0] limit;
  logic [PROD_W-1:0] prod;
  logic signed [63:0] meas_wide;

  always_comb begin
    flags.dir_pos = target > meas;
    flags.dir_neg = target < meas;
    // speed grows unless measured and direction have opposite signs
    grow = !((meas > 0 && flags.dir_neg) || (meas < 0 && flags.dir_pos));
    limit = grow ? accel : decel;
    prod = {{vrmp_pkg::DT_BITS{1'b0}}, limit} * {{(VALUE_WIDTH-1){1'b0}}, dt};
    step = prod[PROD_W-1:vrmp_pkg::DT_BITS];
    meas_wide = {{(64-VALUE_WIDTH){meas[VALUE_WIDTH-1]}}, meas};
    flags.still = (meas_wide < STILL_LIMIT) && (meas_wide > -STILL_LIMIT);
  end

endmodule

`default_nettype wire

// ----- src/vrmp_axis.sv -----
// Per-axis ramp update: restart from measured, step with saturation, clamp at target.
// Depends on vrmp_pkg.
`default_nettype none

module vrmp_axis #(
  parameter int VALUE_WIDTH = vrmp_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic signed [VALUE_WIDTH-1:0] target,
  input  wire logic signed [VALUE_WIDTH-1:0] meas,
  input  wire logic signed [VALUE_WIDTH-1:0] ramp,
  input  wire logic        [VALUE_WIDTH-2:0] step,
  input  wire vrmp_pkg::axis_flags_t         flags,
  output logic signed [VALUE_WIDTH-1:0]      ramp_next
);

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic                          restart;
  logic signed [VALUE_WIDTH-1:0] base;
  logic signed [VALUE_WIDTH:0]   base_x;
  logic signed [VALUE_WIDTH:0]   step_x;
  logic signed [VALUE_WIDTH:0]   sum;
  logic signed [VALUE_WIDTH-1:0] sat;

  always_comb begin
    // measured lies strictly past the ramp on the target side
    restart = (meas > ramp && target > ramp) || (meas < ramp && target < ramp);
    base    = restart ? meas : ramp;
    base_x  = {base[VALUE_WIDTH-1], base};
    step_x  = $signed({2'b00, step});
    if (flags.dir_pos) begin
      sum = base_x + step_x;
    end else if (flags.dir_neg) begin
      sum = base_x - step_x;
    end else begin
      sum = base_x;
    end
    if (sum[VALUE_WIDTH] != sum[VALUE_WIDTH-1]) begin
      sat = sum[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
    end else begin
      sat = sum[VALUE_WIDTH-1:0];
    end
    // overshoot past the target snaps to it
    if ((flags.dir_pos && sat > target) || (flags.dir_neg && sat < target)) begin
      ramp_next = target;
    end else begin
      ramp_next = sat;
    end
  end

endmodule

`default_nettype wire

// ----- src/dual_axis_velocity_ramp_top.sv -----
// Top level of the dual-axis velocity ramp generator: ports, registers, state.
// Depends on vrmp_pkg, vrmp_prep and vrmp_axis.
//
//   channel  | group                          | moves
//   ---------+--------------------------------+-------------------------------------
//   input    | s_axis_tvalid/tready/tdata/user| one tick or enable request per item
//   output   | m_axis_tvalid/tready/tdata     | ramps, flags and spin goals per item
//   config   | cfg_wen/cfg_index/cfg_wdata    | register write, no read-back
//
// One item per cycle sustained while the receiver keeps tready high. An accepted
// item is held in the input register (step products and flags already formed),
// then the ramp update writes state and the result register together. The ramp
// feedback closes in that single update step. A stalled result holds the input
// register; the input side stays ready while the result register is empty or
// being taken. Synchronous reset clears valids, ramps, enable, spin goals and
// config registers.
`default_nettype none

module dual_axis_velocity_ramp_top #(
  parameter int VALUE_WIDTH   = vrmp_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = vrmp_pkg::FRACTION_BITS_DEF,
  localparam int IN_BITS      = 4 * VALUE_WIDTH + 2 + vrmp_pkg::DT_BITS,
  localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS     = 4 * VALUE_WIDTH + 2,
  localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic clk,
  input  wire logic rst,
  // input items
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // lin_target, ang_target, lin_measured, ang_measured, lin_at_limit,
  // ang_at_limit, tick_seconds (lowest bit first), zero pad
  input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,
  // req_type
  input  wire logic                  s_axis_tuser,
  // result items
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // lin_ramp_out, ang_ramp_out, shutdown_now, active, lin_goal_at_spin,
  // ang_goal_at_spin (lowest bit first), zero pad
  output logic [OUT_TDATA_W-1:0]     m_axis_tdata,
  // configuration writes
  input  wire logic                               cfg_wen,
  input  wire logic [vrmp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [VALUE_WIDTH-2:0]             cfg_wdata
);

  localparam int W = VALUE_WIDTH;
  localparam longint LIN_STILL = 64'sd1 <<< FRACTION_BITS;
  localparam longint ANG_STILL = ((64'sd5 <<< FRACTION_BITS) + 64'sd50) / 64'sd100;

  // configuration registers
  logic [W-2:0] lin_accel, lin_decel, ang_accel, ang_decel;
  logic         spin_en;

  // unpacked input fields
  logic                 in_req;
  logic signed [W-1:0]  in_lin_target, in_ang_target, in_lin_meas, in_ang_meas;
  logic                 in_lin_limit, in_ang_limit;
  logic [vrmp_pkg::DT_BITS-1:0] in_dt;

  assign in_req        = s_axis_tuser;
  assign in_lin_target = s_axis_tdata[W-1:0];
  assign in_ang_target = s_axis_tdata[2*W-1:W];
  assign in_lin_meas   = s_axis_tdata[3*W-1:2*W];
  assign in_ang_meas   = s_axis_tdata[4*W-1:3*W];
  assign in_lin_limit  = s_axis_tdata[4*W];
  assign in_ang_limit  = s_axis_tdata[4*W+1];
  assign in_dt         = s_axis_tdata[4*W+1+vrmp_pkg::DT_BITS:4*W+2];

  // step sizes and flags formed ahead of the input register
  vrmp_pkg::axis_flags_t lin_flags_in, ang_flags_in;
  logic [W-2:0]          lin_step_in, ang_step_in;

  vrmp_prep #(.VALUE_WIDTH(W), .STILL_LIMIT(LIN_STILL)) u_lin_prep (
    .target (in_lin_target),
    .meas   (in_lin_meas),
    .accel  (lin_accel),
    .decel  (lin_decel),
    .dt     (in_dt),
    .flags  (lin_flags_in),
    .step   (lin_step_in)
  );

  vrmp_prep #(.VALUE_WIDTH(W), .STILL_LIMIT(ANG_STILL)) u_ang_prep (
    .target (in_ang_target),
    .meas   (in_ang_meas),
    .accel  (ang_accel),
    .decel  (ang_decel),
    .dt     (in_dt),
    .flags  (ang_flags_in),
    .step   (ang_step_in)
  );

  // input register
  logic                  a_valid;
  logic                  a_req;
  logic signed [W-1:0]   a_lin_target, a_ang_target, a_lin_meas, a_ang_meas;
  vrmp_pkg::axis_flags_t a_lin_flags, a_ang_flags;
  logic [W-2:0]          a_lin_step, a_ang_step;
  logic                  a_spin_hit;

  // state
  logic signed [W-1:0] lin_ramp, ang_ramp, lin_goal, ang_goal;
  logic                enabled;

  // result register
  logic                out_valid;
  logic signed [W-1:0] out_lin, out_ang, out_lin_goal, out_ang_goal;
  logic                out_shut, out_active;

  logic in_fire, advance;

  assign advance       = a_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !a_valid || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ramp update logic
  logic signed [W-1:0] lin_ramp_calc, ang_ramp_calc;

  vrmp_axis #(.VALUE_WIDTH(W)) u_lin_axis (
    .target    (a_lin_target),
    .meas      (a_lin_meas),
    .ramp      (lin_ramp),
    .step      (a_lin_step),
    .flags     (a_lin_flags),
    .ramp_next (lin_ramp_calc)
  );

  vrmp_axis #(.VALUE_WIDTH(W)) u_ang_axis (
    .target    (a_ang_target),
    .meas      (a_ang_meas),
    .ramp      (ang_ramp),
    .step      (a_ang_step),
    .flags     (a_ang_flags),
    .ramp_next (ang_ramp_calc)
  );

  // next state for one item
  logic signed [W-1:0] lin_ramp_next, ang_ramp_next, lin_goal_next, ang_goal_next;
  logic                enabled_next, shut_next;

  always_comb begin
    lin_ramp_next = lin_ramp;
    ang_ramp_next = ang_ramp;
    lin_goal_next = lin_goal;
    ang_goal_next = ang_goal;
    enabled_next  = enabled;
    shut_next     = 1'b0;
    if (a_req == vrmp_pkg::REQ_ENABLE) begin
      lin_ramp_next = '0;
      ang_ramp_next = '0;
      enabled_next  = 1'b1;
    end else if (enabled) begin
      lin_ramp_next = lin_ramp_calc;
      ang_ramp_next = ang_ramp_calc;
      // saturated drive while nearly still: capture goals and shut down
      if (a_spin_hit && spin_en) begin
        lin_goal_next = lin_ramp_calc;
        ang_goal_next = ang_ramp_calc;
        enabled_next  = 1'b0;
        shut_next     = 1'b1;
      end
    end
  end

  // control, state and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
      lin_ramp  <= '0;
      ang_ramp  <= '0;
      lin_goal  <= '0;
      ang_goal  <= '0;
      enabled   <= 1'b0;
      lin_accel <= '0;
      lin_decel <= '0;
      ang_accel <= '0;
      ang_decel <= '0;
      spin_en   <= 1'b0;
    end else begin
      if (in_fire) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        lin_ramp  <= lin_ramp_next;
        ang_ramp  <= ang_ramp_next;
        lin_goal  <= lin_goal_next;
        ang_goal  <= ang_goal_next;
        enabled   <= enabled_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wen) begin
        case (cfg_index)
          vrmp_pkg::REG_LIN_ACCEL: lin_accel <= cfg_wdata;
          vrmp_pkg::REG_LIN_DECEL: lin_decel <= cfg_wdata;
          vrmp_pkg::REG_ANG_ACCEL: ang_accel <= cfg_wdata;
          vrmp_pkg::REG_ANG_DECEL: ang_decel <= cfg_wdata;
          vrmp_pkg::REG_SPIN_EN:   spin_en   <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_req        <= in_req;
      a_lin_target <= in_lin_target;
      a_ang_target <= in_ang_target;
      a_lin_meas   <= in_lin_meas;
      a_ang_meas   <= in_ang_meas;
      a_lin_flags  <= lin_flags_in;
      a_ang_flags  <= ang_flags_in;
      a_lin_step   <= lin_step_in;
      a_ang_step   <= ang_step_in;
      a_spin_hit   <= (in_lin_limit || in_ang_limit) &&
                      lin_flags_in.still && ang_flags_in.still;
    end
    if (advance) begin
      out_lin      <= lin_ramp_next;
      out_ang      <= ang_ramp_next;
      out_lin_goal <= lin_goal_next;
      out_ang_goal <= ang_goal_next;
      out_shut     <= shut_next;
      out_active   <= enabled_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}}, out_ang_goal, out_lin_goal,
                          out_active, out_shut, out_ang, out_lin};

endmodule

`default_nettype wire

// ----- test/tb_dual_axis_velocity_ramp_top.sv -----
// Testbench for dual_axis_velocity_ramp_top: stream stimulus, scoreboard with a ramp predictor.
// Depends on vrmp_pkg and the block's RTL; self-checking, no files or arguments.
`timescale 1ns / 100ps

module tb_dual_axis_velocity_ramp_top;
  import vrmp_pkg::*;

  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int FB          = FRACTION_BITS_DEF;
  localparam int IN_TDATA_W  = ((4 * VW + 2 + DT_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((4 * VW + 2 + 7) / 8) * 8;

  // Saturation bounds of a ramp and the stillness limits (0.05 rad/s rounded)
  localparam longint VAL_TOP   = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VAL_BOT   = -VAL_TOP - 1;
  localparam longint LIN_STILL = longint'(1) <<< FB;
  localparam longint ANG_STILL = ((longint'(5) <<< FB) + 50) / 100;

  // Index with no register behind it, writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;

  // Input item, first field in the lowest bits
  typedef struct packed {
    logic [DT_BITS-1:0]   dt;
    logic                 ang_lim;
    logic                 lin_lim;
    logic signed [VW-1:0] ang_meas;
    logic signed [VW-1:0] lin_meas;
    logic signed [VW-1:0] ang_tgt;
    logic signed [VW-1:0] lin_tgt;
  } tick_t;

  // Result item, first field in the lowest bits
  typedef struct packed {
    logic signed [VW-1:0] ang_goal;
    logic signed [VW-1:0] lin_goal;
    logic                 active;
    logic                 shut;
    logic signed [VW-1:0] ang_ramp;
    logic signed [VW-1:0] lin_ramp;
  } ramp_res_t;

  // Ramp predictor plus the queue of results still owed by the block
  class ramp_scoreboard;
    logic [VW-2:0]        lin_acc, lin_dec, ang_acc, ang_dec;
    bit                   spin_en;
    logic signed [VW-1:0] lin_ramp, ang_ramp, lin_goal, ang_goal;
    bit                   enabled;
    ramp_res_t            owed_q[$];
    int                   errors, checked, shutdowns;

    function new();
      lin_acc = '0; lin_dec = '0; ang_acc = '0; ang_dec = '0;
      spin_en = 1'b0;
      lin_ramp = '0; ang_ramp = '0; lin_goal = '0; ang_goal = '0;
      enabled = 1'b0;
      errors = 0; checked = 0; shutdowns = 0;
    endfunction

    static function int sign_of(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    static function longint abs_of(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // One axis: restart from measured if it ran ahead, step, saturate, clamp at target
    static function longint axis_next(longint tgt, longint meas, longint ramp,
                                      longint unsigned acc, longint unsigned dec,
                                      longint unsigned dt);
      int     dir;
      longint step;
      longint nxt;
      dir = sign_of(tgt - meas);
      nxt = ramp;
      if (sign_of(meas - nxt) * sign_of(tgt - nxt) > 0) nxt = meas;
      // speed grows unless measured and the move point opposite ways
      if (sign_of(meas) * dir >= 0) step = longint'((acc * dt) >> 16);
      else step = longint'((dec * dt) >> 16);
      if (dir > 0) nxt = nxt + step;
      else if (dir < 0) nxt = nxt - step;
      if (nxt > VAL_TOP) nxt = VAL_TOP;
      if (nxt < VAL_BOT) nxt = VAL_BOT;
      if (dir * sign_of(tgt - nxt) < 0) nxt = tgt;
      return nxt;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [VW-2:0] val);
      case (idx)
        REG_LIN_ACCEL: lin_acc = val;
        REG_LIN_DECEL: lin_dec = val;
        REG_ANG_ACCEL: ang_acc = val;
        REG_ANG_DECEL: ang_dec = val;
        REG_SPIN_EN:   spin_en = val[0];
        default: ;
      endcase
    endfunction

    function void note_item(logic req, tick_t t);
      ramp_res_t r;
      bit        shut;
      longint    lm, am, nxt;
      shut = 1'b0;
      lm = longint'($signed(t.lin_meas));
      am = longint'($signed(t.ang_meas));
      if (req == REQ_ENABLE) begin
        lin_ramp = '0;
        ang_ramp = '0;
        enabled = 1'b1;
      end else if (enabled) begin
        nxt = axis_next(longint'($signed(t.lin_tgt)), lm, longint'(lin_ramp),
                        lin_acc, lin_dec, t.dt);
        lin_ramp = nxt[VW-1:0];
        nxt = axis_next(longint'($signed(t.ang_tgt)), am, longint'(ang_ramp),
                        ang_acc, ang_dec, t.dt);
        ang_ramp = nxt[VW-1:0];
        if ((t.lin_lim || t.ang_lim) && spin_en &&
            abs_of(lm) < LIN_STILL && abs_of(am) < ANG_STILL) begin
          lin_goal = lin_ramp;
          ang_goal = ang_ramp;
          enabled = 1'b0;
          shut = 1'b1;
          shutdowns++;
        end
      end
      r.lin_ramp = lin_ramp;
      r.ang_ramp = ang_ramp;
      r.shut     = shut;
      r.active   = enabled;
      r.lin_goal = lin_goal;
      r.ang_goal = ang_goal;
      owed_q.push_back(r);
    endfunction

    function void field_cmp(string name, logic [VW-1:0] want, logic [VW-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(ramp_res_t got);
      ramp_res_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: result with none expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      checked++;
      field_cmp("lin_ramp_out", want.lin_ramp, got.lin_ramp);
      field_cmp("ang_ramp_out", want.ang_ramp, got.ang_ramp);
      field_cmp("shutdown_now", VW'(want.shut), VW'(got.shut));
      field_cmp("active", VW'(want.active), VW'(got.active));
      field_cmp("lin_goal_at_spin", want.lin_goal, got.lin_goal);
      field_cmp("ang_goal_at_spin", want.ang_goal, got.ang_goal);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  // Clock, reset and every block input start at known values
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = REQ_TICK;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_wen = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [VW-2:0]          cfg_wdata = '0;

  ramp_scoreboard sb;
  int src_idle_pct = 0;   // chance per cycle that the sender holds back
  int sink_stall_pct = 0; // chance per cycle that the receiver drops tready
  int hold_left = 0;      // long receiver hold-off, counted down by the receiver
  int items_sent = 0;
  int reg_sets = 0;

  always #2 clk = ~clk;

  dual_axis_velocity_ramp_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // Receiver: check what was taken at this edge (pre-edge values), then pick
  // tready for the next cycle. A pending long hold-off overrides the random stall.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_result(ramp_res_t'(m_axis_tdata[$bits(ramp_res_t)-1:0]));
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  // Random magnitude up to lim with random sign
  function automatic logic [VW-1:0] rand_small(int unsigned lim);
    logic [VW-1:0] v;
    v = VW'($urandom_range(0, lim));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Velocities: extremes, full range, near-still and moderate values
  function automatic logic [VW-1:0] rand_vel();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return '0;
          default: return '1;
        endcase
      end
      1: return VW'($urandom());
      2: return rand_small(70000);
      3: return rand_small(4000);
      default: return rand_small(5 << FB);
    endcase
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.lin_tgt  = rand_vel();
    t.ang_tgt  = rand_vel();
    t.lin_meas = rand_vel();
    t.ang_meas = rand_vel();
    case ($urandom_range(0, 9))
      // robot nearly still, so saturation can trip the spin shutdown
      0, 1: begin
        t.lin_meas = rand_small(70000);
        t.ang_meas = rand_small(4000);
      end
      2: t.lin_meas = t.lin_tgt;
      3: t.ang_meas = t.ang_tgt;
      default: ;
    endcase
    t.lin_lim = ($urandom_range(0, 99) < 30);
    t.ang_lim = ($urandom_range(0, 99) < 30);
    case ($urandom_range(0, 7))
      0: t.dt = '0;
      1: t.dt = '1;
      2, 3: t.dt = DT_BITS'($urandom());
      default: t.dt = DT_BITS'($urandom_range(1, 2000));
    endcase
    return t;
  endfunction

  // Offer one item after an optional random gap; tvalid stays up on return so
  // a following item goes back to back.
  task automatic push_item(logic req, tick_t t);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'(t);
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(req, t);
    items_sent++;
  endtask

  task automatic push_tick(logic [VW-1:0] lt, logic [VW-1:0] at, logic [VW-1:0] lm,
                           logic [VW-1:0] am, logic ll, logic al, logic [DT_BITS-1:0] dt);
    tick_t t;
    t.lin_tgt = lt; t.ang_tgt = at; t.lin_meas = lm; t.ang_meas = am;
    t.lin_lim = ll; t.ang_lim = al; t.dt = dt;
    push_item(REQ_TICK, t);
  endtask

  // Stop offering and wait until every owed result is out, plus the pipe depth
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write; cfg_wen is left high so writes can go back to back
  task automatic cfg_put(logic [CFG_INDEX_W-1:0] idx, logic [VW-2:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // Full register set, junk in the unused upper bits of the spin flag, and a
  // stray write to an unmapped index
  task automatic program_regs(logic [VW-2:0] la, logic [VW-2:0] ld, logic [VW-2:0] aa,
                              logic [VW-2:0] ad, logic spin);
    cfg_put(REG_LIN_ACCEL, la);
    cfg_put(REG_LIN_DECEL, ld);
    cfg_put(REG_ANG_ACCEL, aa);
    cfg_put(REG_ANG_DECEL, ad);
    cfg_put(REG_SPIN_EN, {(VW - 2)'($urandom()), spin});
    cfg_put(REG_NONE, (VW - 1)'($urandom()));
    cfg_wen <= 1'b0;
    reg_sets++;
  endtask

  function automatic logic [VW-2:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return (VW - 1)'($urandom());
      default: return (VW - 1)'($urandom_range(1, 1 << 22));
    endcase
  endfunction

  // Mostly ticks on an enabled block; a disabled block is re-enabled quickly
  task automatic random_burst(int n);
    for (int i = 0; i < n; i++) begin
      if (!sb.enabled ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 99) < 4))
        push_item(REQ_ENABLE, rand_tick());
      else
        push_item(REQ_TICK, rand_tick());
    end
  endtask

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // tick before any enable is ignored
    push_tick(32'h0005_0000, 32'h0001_0000, '0, '0, 1'b0, 1'b0, 16'hffff);
    push_item(REQ_ENABLE, rand_tick());
    // all limits still zero: ramps stay put, saturation ignored with shutdown off
    push_tick(32'h0005_0000, -32'sd65536, '0, '0, 1'b1, 1'b1, 16'hffff);
    settle();
    program_regs(31'h7fff_ffff, 31'h7fff_ffff, 31'h0010_0000, 31'h0008_0000, 1'b1);
    // steps toward both extremes with the longest tick; the linear ramp saturates
    push_tick(32'h7fff_ffff, 32'h8000_0000, 32'h0002_0000, -32'sd131072, 1'b0, 1'b0, 16'hffff);
    // swing back: measured opposes the move, so the decel limit applies
    push_tick(32'h8000_0000, 32'h7fff_ffff, 32'h0003_0000, -32'sd196608, 1'b0, 1'b0, 16'hffff);
    // target equals measured: no move past the restart rule
    push_tick(32'h0003_0000, -32'sd65536, 32'h0003_0000, -32'sd65536, 1'b0, 1'b0, 16'h1000);
    // slowing down toward a smaller target
    push_tick(32'h0001_0000, 32'h0000_8000, 32'h0004_0000, 32'h0002_0000, 1'b0, 1'b0, 16'h0100);
    // enable while enabled zeroes the ramps again
    push_item(REQ_ENABLE, rand_tick());
    // measured ahead of the ramp on the target side: restart from measured
    push_tick(32'h000a_0000, -32'sd655360, 32'h0002_0000, -32'sd131072, 1'b0, 1'b0, 16'h0010);
    // stillness edges: exactly 1.0 and exactly the angular limit are not still
    push_tick('0, '0, 32'h0001_0000, '0, 1'b1, 1'b0, 16'h0040);
    push_tick('0, '0, '0, 32'd3277, 1'b0, 1'b1, 16'h0040);
    push_tick('0, '0, -32'sd65536, -32'sd3277, 1'b1, 1'b1, 16'h0040);
    // just inside both limits with angular saturation: spin shutdown
    push_tick(32'h0002_0000, 32'h0000_4000, -32'sd65535, -32'sd3276, 1'b0, 1'b1, 16'h0800);
    // disabled after shutdown: ignored
    push_tick(32'h0004_0000, 32'h0004_0000, '0, '0, 1'b1, 1'b1, 16'h0800);
    push_item(REQ_ENABLE, rand_tick());
    settle();
    // shutdown disabled: still robot with saturation keeps running
    program_regs(31'h0000_1000, 31'h0000_2000, 31'h0000_3000, 31'h0000_4000, 1'b0);
    push_tick(32'h0001_0000, '0, '0, 32'd3276, 1'b1, 1'b1, 16'h0100);
    settle();
    // zero timestep with linear saturation: shutdown captures the ramps as they stand
    program_regs('0, '0, 31'h7fff_ffff, '0, 1'b1);
    push_tick(-32'sd65536, 32'h0001_0000, 32'd100, -32'sd100, 1'b1, 1'b0, 16'h0000);

    // ---- random part: several register settings, each under one idle mix ----
    for (int set = 0; set < 8; set++) begin
      settle();
      case (set)
        0: program_regs('1, '1, '1, '1, 1'b1);
        1: program_regs('0, '0, '0, '0, 1'b0);
        default: program_regs(rand_rate(), rand_rate(), rand_rate(), rand_rate(), set[0]);
      endcase
      case (set % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
        default: begin src_idle_pct = 17; sink_stall_pct = 17; end
      endcase
      push_item(REQ_ENABLE, rand_tick());
      random_burst(130);
    end

    // ---- back-pressure: receiver holds off while the sender keeps offering ----
    settle();
    program_regs(rand_rate(), rand_rate(), rand_rate(), rand_rate(), 1'b1);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    push_item(REQ_ENABLE, rand_tick());
    hold_left = 300;
    random_burst(60);

    // drain, then wait on to catch any stray result
    settle();
    repeat (10) @(posedge clk);
    $display("Run covered %0d items, %0d results checked, %0d spin shutdowns,",
             items_sent, sb.checked, sb.shutdowns);
    $display("%0d register settings, four idle/stall mixes and a long output hold-off.",
             reg_sets);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** dual_axis_velocity_ramp_top: PASSED **");
    else
      $display("** dual_axis_velocity_ramp_top: FAILED **");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("** dual_axis_velocity_ramp_top: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/vrmp_pkg.sv
src/vrmp_prep.sv
src/vrmp_axis.sv
src/dual_axis_velocity_ramp_top.sv
test/tb_dual_axis_velocity_ramp_top.sv
